[hw/rtl/aps_pkg.sv]
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types, register map, action codes and the persistence counter step
// for the alarm persistence status unit.
// ----------------------------------------------------------------------------
package aps_pkg;

  localparam int CHANNELS = 5;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register indexes
  localparam logic [2:0] REG_LEDS_ENABLED  = 3'd0;
  localparam logic [2:0] REG_RUNTIME_LIMIT = 3'd1;
  localparam logic [2:0] REG_DEVICE_LIMIT  = 3'd2;
  localparam logic [2:0] REG_POLL_PERIOD   = 3'd3;
  localparam logic [2:0] REG_WARN_LED_MASK = 3'd4;
  localparam logic [2:0] REG_WARN_KEEP     = 3'd5;

  // actions
  localparam logic [2:0] ACT_TICK       = 3'd0;
  localparam logic [2:0] ACT_SET_ALARM  = 3'd1;
  localparam logic [2:0] ACT_CLR_ALARM  = 3'd2;
  localparam logic [2:0] ACT_SET_WARN   = 3'd3;
  localparam logic [2:0] ACT_CLR_WARN   = 3'd4;
  localparam logic [2:0] ACT_CLEAR_ALL  = 3'd5;

  // alarm bit positions
  localparam int ALM_RUNTIME  = 0;
  localparam int ALM_INIT     = 1;
  localparam int ALM_SYNC     = 2;
  localparam int ALM_DSP      = 3;
  localparam int ALM_OVERTEMP = 4;
  localparam int ALM_LIC_LO   = 5;
  localparam int ALM_LIC_HI   = 6;

  typedef struct packed {
    logic [2:0]          action;
    logic [15:0]         bit_mask;
    logic [CHANNELS-1:0] runtime_fault;
    logic [CHANNELS-1:0] init_fault;
    logic [CHANNELS-1:0] monitored;
    logic                link_valid;
    logic [CHANNELS-1:0] sync_fault;
    logic [CHANNELS-1:0] dsp_fault;
    logic [CHANNELS-1:0] overtemp_fault;
  } item_t;

  typedef struct packed {
    logic [15:0] alarm_word;
    logic [15:0] warning_word;
    logic        led_update;
    logic        warning_led;
    logic        alarm_led;
    logic        ready_steady;
    logic        ready_blink;
  } result_t;

  typedef struct packed {
    logic        leds_enabled;
    logic [7:0]  runtime_limit;
    logic [7:0]  device_limit;
    logic [3:0]  poll_period;
    logic [15:0] warning_led_mask;
    logic [15:0] warning_keep_mask;
  } cfg_t;

  typedef struct packed {
    logic runtime;
    logic sync;
    logic dsp;
    logic overtemp;
  } lane_hit_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] cnt;
  } persist_t;

  function automatic persist_t persist(logic [7:0] cnt, logic fault, logic [7:0] limit);
    persist_t   r;
    logic [7:0] inc;
    inc   = fault ? cnt + 8'd1 : 8'd0;
    r.hit = (inc >= limit);
    r.cnt = r.hit ? 8'd0 : inc;
    return r;
  endfunction

endpackage

[hw/rtl/aps_in_if.sv]
// ----------------------------------------------------------------------------
// aps_in_if
// Valid/ready channel carrying one input word.
// ----------------------------------------------------------------------------
interface aps_in_if;
  logic          valid;
  logic          ready;
  aps_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/aps_out_if.sv]
// ----------------------------------------------------------------------------
// aps_out_if
// Valid/ready channel carrying one status word.
// ----------------------------------------------------------------------------
interface aps_out_if;
  logic             valid;
  logic             ready;
  aps_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/aps_cfg.sv]
// ----------------------------------------------------------------------------
// aps_cfg
// APB register file holding the LED enable, limits, poll period and warning masks.
// ----------------------------------------------------------------------------
module aps_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aps_pkg::ADDR_W-1:0] paddr,
  input  logic [aps_pkg::DATA_W-1:0] pwdata,
  output logic [aps_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output aps_pkg::cfg_t              cfg
);

  logic [2:0] index;
  logic       wr;

  assign index  = paddr[aps_pkg::ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leds_enabled      <= 1'b0;
      cfg.runtime_limit     <= 8'd10;
      cfg.device_limit      <= 8'd107;
      cfg.poll_period       <= 4'd4;
      cfg.warning_led_mask  <= 16'hFFFF;
      cfg.warning_keep_mask <= 16'h0001;
    end else if (wr) begin
      case (index)
        aps_pkg::REG_LEDS_ENABLED:  cfg.leds_enabled      <= pwdata[0];
        aps_pkg::REG_RUNTIME_LIMIT: cfg.runtime_limit     <= pwdata[7:0];
        aps_pkg::REG_DEVICE_LIMIT:  cfg.device_limit      <= pwdata[7:0];
        aps_pkg::REG_POLL_PERIOD:   cfg.poll_period       <= pwdata[3:0];
        aps_pkg::REG_WARN_LED_MASK: cfg.warning_led_mask  <= pwdata[15:0];
        aps_pkg::REG_WARN_KEEP:     cfg.warning_keep_mask <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      aps_pkg::REG_LEDS_ENABLED:  prdata = {31'd0, cfg.leds_enabled};
      aps_pkg::REG_RUNTIME_LIMIT: prdata = {24'd0, cfg.runtime_limit};
      aps_pkg::REG_DEVICE_LIMIT:  prdata = {24'd0, cfg.device_limit};
      aps_pkg::REG_POLL_PERIOD:   prdata = {28'd0, cfg.poll_period};
      aps_pkg::REG_WARN_LED_MASK: prdata = {16'd0, cfg.warning_led_mask};
      aps_pkg::REG_WARN_KEEP:     prdata = {16'd0, cfg.warning_keep_mask};
      default:                    prdata = '0;
    endcase
  end

endmodule

[hw/rtl/aps_lane.sv]
// ----------------------------------------------------------------------------
// aps_lane
// Per-channel persistence counters for runtime, sync, DSP and overtemperature
// faults; reports which counters reached their limit on this tick.
// ----------------------------------------------------------------------------
module aps_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick,
  input  logic               sample,
  input  logic               monitored,
  input  logic               link_valid,
  input  logic               runtime_fault,
  input  logic               sync_fault,
  input  logic               dsp_fault,
  input  logic               overtemp_fault,
  input  logic [7:0]         runtime_limit,
  input  logic [7:0]         device_limit,
  output aps_pkg::lane_hit_t hit
);

  logic [7:0] runtime_count;
  logic [7:0] sync_count;
  logic [7:0] dsp_count;
  logic [7:0] overtemp_count;

  aps_pkg::persist_t rt_p, sy_p, ds_p, ot_p;

  always_comb begin
    rt_p = aps_pkg::persist(runtime_count, runtime_fault, runtime_limit);
    sy_p = aps_pkg::persist(sync_count, link_valid && sync_fault, device_limit);
    ds_p = aps_pkg::persist(dsp_count, dsp_fault, device_limit);
    ot_p = aps_pkg::persist(overtemp_count, overtemp_fault, device_limit);
    hit.runtime  = sample && rt_p.hit;
    hit.sync     = monitored && sy_p.hit;
    hit.dsp      = monitored && ds_p.hit;
    hit.overtemp = monitored && ot_p.hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      runtime_count  <= 8'd0;
      sync_count     <= 8'd0;
      dsp_count      <= 8'd0;
      overtemp_count <= 8'd0;
    end else if (tick) begin
      if (sample) begin
        runtime_count <= rt_p.cnt;
      end
      if (monitored) begin
        sync_count     <= sy_p.cnt;
        dsp_count      <= ds_p.cnt;
        overtemp_count <= ot_p.cnt;
      end
    end
  end

endmodule

[hw/rtl/aps_merge.sv]
// ----------------------------------------------------------------------------
// aps_merge
// Combines lane results into the sticky alarm and warning words, runs the
// poll divider and holds the output register.
// ----------------------------------------------------------------------------
module aps_merge (
  input  logic                                       clk,
  input  logic                                       rst,
  aps_in_if.sink                                     item,
  aps_out_if.source                                  result,
  input  aps_pkg::cfg_t                              cfg,
  input  aps_pkg::lane_hit_t [aps_pkg::CHANNELS-1:0] hits,
  output logic                                       tick,
  output logic                                       sample
);

  logic [15:0] alarm_bits, alarm_next;
  logic [15:0] warning_bits, warning_next;
  logic [3:0]  poll_divider, divider_next;
  logic        out_valid;
  aps_pkg::result_t out_word, out_next;
  logic        fire;
  logic        drive;
  logic        any_rt, any_sync, any_dsp, any_ot, lic;

  assign item.ready   = !out_valid || result.ready;
  assign fire         = item.valid && item.ready;
  assign tick         = fire && (item.data.action == aps_pkg::ACT_TICK);
  assign sample       = (poll_divider <= 4'd1);
  assign result.valid = out_valid;
  assign result.data  = out_word;

  always_comb begin
    any_rt   = 1'b0;
    any_sync = 1'b0;
    any_dsp  = 1'b0;
    any_ot   = 1'b0;
    for (int i = 0; i < aps_pkg::CHANNELS; i++) begin
      any_rt   = any_rt   | hits[i].runtime;
      any_sync = any_sync | hits[i].sync;
      any_dsp  = any_dsp  | hits[i].dsp;
      any_ot   = any_ot   | hits[i].overtemp;
    end
    lic = alarm_bits[aps_pkg::ALM_LIC_LO] || alarm_bits[aps_pkg::ALM_LIC_HI];

    alarm_next   = alarm_bits;
    warning_next = warning_bits;
    divider_next = poll_divider;
    drive        = 1'b0;
    case (item.data.action)
      aps_pkg::ACT_TICK: begin
        drive = cfg.leds_enabled;
        if (sample) begin
          divider_next = cfg.poll_period;
          if (any_rt) alarm_next[aps_pkg::ALM_RUNTIME] = 1'b1;
          if (|item.data.init_fault) alarm_next[aps_pkg::ALM_INIT] = 1'b1;
        end else begin
          divider_next = poll_divider - 4'd1;
        end
        if (lic) begin
          if (|item.data.monitored) alarm_next[aps_pkg::ALM_SYNC] = 1'b0;
        end else if (any_sync) begin
          alarm_next[aps_pkg::ALM_SYNC] = 1'b1;
        end
        if (any_dsp) alarm_next[aps_pkg::ALM_DSP] = 1'b1;
        if (any_ot) alarm_next[aps_pkg::ALM_OVERTEMP] = 1'b1;
      end
      aps_pkg::ACT_SET_ALARM: alarm_next   = alarm_bits | item.data.bit_mask;
      aps_pkg::ACT_CLR_ALARM: alarm_next   = alarm_bits & ~item.data.bit_mask;
      aps_pkg::ACT_SET_WARN:  warning_next = warning_bits | item.data.bit_mask;
      aps_pkg::ACT_CLR_WARN:  warning_next = warning_bits & ~item.data.bit_mask;
      aps_pkg::ACT_CLEAR_ALL: begin
        alarm_next   = 16'd0;
        warning_next = warning_bits & cfg.warning_keep_mask;
      end
      default: ;
    endcase

    out_next.alarm_word   = alarm_next;
    out_next.warning_word = warning_next;
    out_next.led_update   = drive;
    out_next.warning_led  = drive && ((warning_next & cfg.warning_led_mask) != 16'd0);
    out_next.alarm_led    = drive && (alarm_next != 16'd0);
    out_next.ready_steady = drive && (alarm_next == 16'd0);
    out_next.ready_blink  = drive && (alarm_next != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_bits   <= 16'd0;
      warning_bits <= 16'd0;
      poll_divider <= 4'd0;
      out_valid    <= 1'b0;
    end else if (fire) begin
      alarm_bits   <= alarm_next;
      warning_bits <= warning_next;
      poll_divider <= divider_next;
      out_valid    <= 1'b1;
    end else if (result.ready) begin
      out_valid    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= out_next;
    end
  end

endmodule

[hw/rtl/alarm_persistence_status_unit.sv]
// ----------------------------------------------------------------------------
// alarm_persistence_status_unit
// Sticky alarm/warning status with per-channel fault persistence counters.
// ----------------------------------------------------------------------------
// Takes one input word per clock unless stalled and returns one status word
// per input through a single output register; input ready stays high while
// that register is empty or being drained. Each channel has its own counter
// lane, all lanes update in the same cycle, and one merge stage folds their
// limit hits into the alarm word. Counters reset at once with rst; there is
// no clearing pass. Registers are written over APB at byte address 4*index
// only while no word is in flight, a user rule the block does not enforce.
module alarm_persistence_status_unit (
  input  logic                       clk,
  input  logic                       rst,
  aps_in_if.sink                     item,
  aps_out_if.source                  result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aps_pkg::ADDR_W-1:0] paddr,
  input  logic [aps_pkg::DATA_W-1:0] pwdata,
  output logic [aps_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  aps_pkg::cfg_t                              cfg;
  aps_pkg::lane_hit_t [aps_pkg::CHANNELS-1:0] hits;
  logic                                       tick;
  logic                                       sample;

  aps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  for (genvar i = 0; i < aps_pkg::CHANNELS; i++) begin : g_lane
    aps_lane u_lane (
      .clk            (clk),
      .rst            (rst),
      .tick           (tick),
      .sample         (sample),
      .monitored      (item.data.monitored[i]),
      .link_valid     (item.data.link_valid),
      .runtime_fault  (item.data.runtime_fault[i]),
      .sync_fault     (item.data.sync_fault[i]),
      .dsp_fault      (item.data.dsp_fault[i]),
      .overtemp_fault (item.data.overtemp_fault[i]),
      .runtime_limit  (cfg.runtime_limit),
      .device_limit   (cfg.device_limit),
      .hit            (hits[i])
    );
  end

  aps_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg),
    .hits   (hits),
    .tick   (tick),
    .sample (sample)
  );

  a_led_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.data.ready_steady && result.data.alarm_led))
    else $error("ready_steady and alarm_led both set");

  a_led_gated: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.data.led_update |->
      !(result.data.warning_led || result.data.alarm_led ||
        result.data.ready_steady || result.data.ready_blink))
    else $error("LED field set without led_update");

  a_blink_matches: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.data.ready_blink == result.data.alarm_led))
    else $error("ready_blink differs from alarm_led");

  a_license_blocks_sync: assert property (@(posedge clk) disable iff (rst)
    tick && (item.data.monitored != '0) |=>
      (result.data.alarm_word[aps_pkg::ALM_LIC_HI:aps_pkg::ALM_LIC_LO] == 2'd0) ||
      !result.data.alarm_word[aps_pkg::ALM_SYNC])
    else $error("sync alarm set while license alarm present");

endmodule

[dv/aps_status_checker.sv]
// ----------------------------------------------------------------------------
// aps_status_checker
// Watches the input, status and register channels of the alarm persistence
// status unit. Keeps its own copy of the sticky words, the persistence
// counters, the poll divider and the register settings, works out the status
// word every accepted input word should produce and compares each returned
// status word, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module aps_status_checker (
  input  logic                       clk,
  input  logic                       rst,
  aps_in_if                          item,
  aps_out_if                         result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aps_pkg::ADDR_W-1:0] paddr,
  input  logic [aps_pkg::DATA_W-1:0] pwdata,
  input  logic                       pready,
  output int                         errors,
  output int                         pending
);

  aps_pkg::cfg_t    cfg;
  logic [15:0]      alarm_q;
  logic [15:0]      warn_q;
  logic [7:0]       rt_cnt [aps_pkg::CHANNELS];
  logic [7:0]       sy_cnt [aps_pkg::CHANNELS];
  logic [7:0]       ds_cnt [aps_pkg::CHANNELS];
  logic [7:0]       ot_cnt [aps_pkg::CHANNELS];
  logic [3:0]       poll_div;
  aps_pkg::result_t status_due [$];

  function automatic logic [8:0] count_step(logic [7:0] cnt, logic fault, logic [7:0] limit);
    logic [7:0] nxt;
    nxt = fault ? cnt + 8'd1 : 8'd0;
    return (nxt >= limit) ? {1'b1, 8'd0} : {1'b0, nxt};
  endfunction

  function automatic aps_pkg::result_t advance_status(aps_pkg::item_t w);
    aps_pkg::result_t r;
    logic [8:0]       s;
    logic [8:0]       d;
    logic [8:0]       o;
    logic [8:0]       q;
    logic             drive;
    drive = 1'b0;
    case (w.action)
      aps_pkg::ACT_TICK: begin
        if (poll_div <= 4'd1) begin
          for (int ch = 0; ch < aps_pkg::CHANNELS; ch++) begin
            q = count_step(rt_cnt[ch], w.runtime_fault[ch], cfg.runtime_limit);
            rt_cnt[ch] = q[7:0];
            if (q[8]) alarm_q[aps_pkg::ALM_RUNTIME] = 1'b1;
            if (w.init_fault[ch]) alarm_q[aps_pkg::ALM_INIT] = 1'b1;
          end
          poll_div = cfg.poll_period;
        end else begin
          poll_div = poll_div - 4'd1;
        end
        for (int ch = 0; ch < aps_pkg::CHANNELS; ch++) begin
          if (w.monitored[ch]) begin
            s = count_step(sy_cnt[ch], w.link_valid && w.sync_fault[ch], cfg.device_limit);
            d = count_step(ds_cnt[ch], w.dsp_fault[ch], cfg.device_limit);
            o = count_step(ot_cnt[ch], w.overtemp_fault[ch], cfg.device_limit);
            sy_cnt[ch] = s[7:0];
            ds_cnt[ch] = d[7:0];
            ot_cnt[ch] = o[7:0];
            if (s[8] && alarm_q[aps_pkg::ALM_LIC_HI:aps_pkg::ALM_LIC_LO] == 2'b00)
              alarm_q[aps_pkg::ALM_SYNC] = 1'b1;
            if (alarm_q[aps_pkg::ALM_LIC_HI:aps_pkg::ALM_LIC_LO] != 2'b00)
              alarm_q[aps_pkg::ALM_SYNC] = 1'b0;
            if (d[8]) alarm_q[aps_pkg::ALM_DSP] = 1'b1;
            if (o[8]) alarm_q[aps_pkg::ALM_OVERTEMP] = 1'b1;
          end
        end
        drive = cfg.leds_enabled;
      end
      aps_pkg::ACT_SET_ALARM: alarm_q = alarm_q | w.bit_mask;
      aps_pkg::ACT_CLR_ALARM: alarm_q = alarm_q & ~w.bit_mask;
      aps_pkg::ACT_SET_WARN:  warn_q = warn_q | w.bit_mask;
      aps_pkg::ACT_CLR_WARN:  warn_q = warn_q & ~w.bit_mask;
      aps_pkg::ACT_CLEAR_ALL: begin
        alarm_q = '0;
        warn_q  = warn_q & cfg.warning_keep_mask;
      end
      default: ;
    endcase
    r.alarm_word   = alarm_q;
    r.warning_word = warn_q;
    r.led_update   = drive;
    r.warning_led  = drive && ((warn_q & cfg.warning_led_mask) != 16'd0);
    r.alarm_led    = drive && (alarm_q != 16'd0);
    r.ready_steady = drive && (alarm_q == 16'd0);
    r.ready_blink  = drive && (alarm_q != 16'd0);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    aps_pkg::result_t exp;
    aps_pkg::result_t got;
    string            bad;
    if (rst) begin
      cfg.leds_enabled      = 1'b0;
      cfg.runtime_limit     = 8'd10;
      cfg.device_limit      = 8'd107;
      cfg.poll_period       = 4'd4;
      cfg.warning_led_mask  = 16'hFFFF;
      cfg.warning_keep_mask = 16'h0001;
      alarm_q  = '0;
      warn_q   = '0;
      poll_div = '0;
      errors   = 0;
      for (int ch = 0; ch < aps_pkg::CHANNELS; ch++) begin
        rt_cnt[ch] = '0;
        sy_cnt[ch] = '0;
        ds_cnt[ch] = '0;
        ot_cnt[ch] = '0;
      end
      status_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[aps_pkg::ADDR_W-1:2])
          aps_pkg::REG_LEDS_ENABLED:  cfg.leds_enabled      = pwdata[0];
          aps_pkg::REG_RUNTIME_LIMIT: cfg.runtime_limit     = pwdata[7:0];
          aps_pkg::REG_DEVICE_LIMIT:  cfg.device_limit      = pwdata[7:0];
          aps_pkg::REG_POLL_PERIOD:   cfg.poll_period       = pwdata[3:0];
          aps_pkg::REG_WARN_LED_MASK: cfg.warning_led_mask  = pwdata[15:0];
          aps_pkg::REG_WARN_KEEP:     cfg.warning_keep_mask = pwdata[15:0];
          default: ;
        endcase
      end
      if (item.valid && item.ready) status_due.push_back(advance_status(item.data));
      if (result.valid && result.ready) begin
        got = result.data;
        if (status_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected status word: alarm %h warning %h leds %b",
                     got.alarm_word, got.warning_word,
                     {got.led_update, got.warning_led, got.alarm_led,
                      got.ready_steady, got.ready_blink});
        end else begin
          exp = status_due.pop_front();
          bad = "";
          if (got.alarm_word !== exp.alarm_word) bad = {bad, " alarm_word"};
          if (got.warning_word !== exp.warning_word) bad = {bad, " warning_word"};
          if (got.led_update !== exp.led_update) bad = {bad, " led_update"};
          if (got.warning_led !== exp.warning_led) bad = {bad, " warning_led"};
          if (got.alarm_led !== exp.alarm_led) bad = {bad, " alarm_led"};
          if (got.ready_steady !== exp.ready_steady) bad = {bad, " ready_steady"};
          if (got.ready_blink !== exp.ready_blink) bad = {bad, " ready_blink"};
          if (bad != "") begin
            errors++;
            if (errors <= 10)
              $display({"status word mismatch in%s: expected alarm %h warning %h ",
                        "leds %b, got alarm %h warning %h leds %b"},
                       bad, exp.alarm_word, exp.warning_word,
                       {exp.led_update, exp.warning_led, exp.alarm_led,
                        exp.ready_steady, exp.ready_blink},
                       got.alarm_word, got.warning_word,
                       {got.led_update, got.warning_led, got.alarm_led,
                        got.ready_steady, got.ready_blink});
          end
        end
      end
    end
    pending = status_due.size();
  end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the alarm persistence status unit. Runs a short
// directed sequence over every action, license blocking and LED states, then
// several register settings, extremes included, each with random input words
// built from slowly changing fault patterns so that persistence counters reach
// their limits. Most phases idle both sides at random; a checker does the rest.
// ----------------------------------------------------------------------------
module tb;

  localparam int STALL_LIMIT = 200;

  typedef logic [aps_pkg::CHANNELS-1:0] chan_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [aps_pkg::ADDR_W-1:0] paddr;
  logic [aps_pkg::DATA_W-1:0] pwdata;
  logic [aps_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  int                         errors;
  int                         pending;
  int                         idle_cycles = 0;
  logic                       idle_on = 1'b0;

  chan_t rt_pat   = '0;
  chan_t init_pat = '0;
  chan_t mon_pat  = '1;
  chan_t sync_pat = '0;
  chan_t dsp_pat  = '0;
  chan_t ot_pat   = '0;

  aps_in_if  item_ch ();
  aps_out_if result_ch ();

  alarm_persistence_status_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  aps_status_checker u_chk (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .errors  (errors),
    .pending (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) ||
        (result_ch.valid && result_ch.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : drain_side
    int n;
    result_ch.ready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      n = idle_on ? $urandom_range(0, 3) : 0;
      if (n > 0) begin
        result_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(negedge clk); while (!result_ch.valid);
      @(posedge clk);
    end
  end

  task automatic send_word(aps_pkg::item_t w);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= w;
    do @(negedge clk); while (!item_ch.ready);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [aps_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_config(logic le, logic [7:0] rl, logic [7:0] dl, logic [3:0] pp,
                             logic [15:0] lm, logic [15:0] km);
    item_ch.valid <= 1'b0;
    wait_drained();
    write_reg(aps_pkg::REG_LEDS_ENABLED, aps_pkg::DATA_W'(le));
    write_reg(aps_pkg::REG_RUNTIME_LIMIT, aps_pkg::DATA_W'(rl));
    write_reg(aps_pkg::REG_DEVICE_LIMIT, aps_pkg::DATA_W'(dl));
    write_reg(aps_pkg::REG_POLL_PERIOD, aps_pkg::DATA_W'(pp));
    write_reg(aps_pkg::REG_WARN_LED_MASK, aps_pkg::DATA_W'(lm));
    write_reg(aps_pkg::REG_WARN_KEEP, aps_pkg::DATA_W'(km));
  endtask

  function automatic aps_pkg::item_t mk(logic [2:0] a, logic [15:0] m, chan_t rt,
                                        chan_t ini, chan_t mon, logic lk, chan_t sy,
                                        chan_t ds, chan_t ot);
    aps_pkg::item_t w;
    w.action         = a;
    w.bit_mask       = m;
    w.runtime_fault  = rt;
    w.init_fault     = ini;
    w.monitored      = mon;
    w.link_valid     = lk;
    w.sync_fault     = sy;
    w.dsp_fault      = ds;
    w.overtemp_fault = ot;
    return w;
  endfunction

  function automatic aps_pkg::item_t random_word();
    aps_pkg::item_t w;
    int             r;
    logic           noise;
    if ($urandom_range(0, 7) == 0) rt_pat = chan_t'($urandom);
    if ($urandom_range(0, 15) == 0) init_pat = chan_t'($urandom) & chan_t'($urandom);
    if ($urandom_range(0, 7) == 0) mon_pat = chan_t'($urandom) | chan_t'($urandom);
    if ($urandom_range(0, 7) == 0) sync_pat = chan_t'($urandom);
    if ($urandom_range(0, 7) == 0) dsp_pat = chan_t'($urandom);
    if ($urandom_range(0, 7) == 0) ot_pat = chan_t'($urandom);
    r = $urandom_range(0, 99);
    w.action = (r < 62) ? aps_pkg::ACT_TICK :
               (r < 68) ? aps_pkg::ACT_SET_ALARM :
               (r < 74) ? aps_pkg::ACT_CLR_ALARM :
               (r < 81) ? aps_pkg::ACT_SET_WARN :
               (r < 87) ? aps_pkg::ACT_CLR_WARN :
               (r < 96) ? aps_pkg::ACT_CLEAR_ALL : 3'($urandom_range(6, 7));
    w.bit_mask = 16'($urandom);
    if ((w.action == aps_pkg::ACT_SET_ALARM || w.action == aps_pkg::ACT_CLR_ALARM) &&
        $urandom_range(0, 1) == 1)
      w.bit_mask = w.bit_mask & 16'h0060;
    noise = ($urandom_range(0, 9) == 0);
    w.runtime_fault  = noise ? chan_t'($urandom) : rt_pat;
    w.init_fault     = noise ? chan_t'($urandom) : init_pat;
    w.monitored      = noise ? chan_t'($urandom) : mon_pat;
    w.sync_fault     = noise ? chan_t'($urandom) : sync_pat;
    w.dsp_fault      = noise ? chan_t'($urandom) : dsp_pat;
    w.overtemp_fault = noise ? chan_t'($urandom) : ot_pat;
    w.link_valid     = ($urandom_range(0, 9) != 0);
    return w;
  endfunction

  task automatic run_phase(logic le, logic [7:0] rl, logic [7:0] dl, logic [3:0] pp,
                           logic [15:0] lm, logic [15:0] km, logic idle, int n);
    load_config(le, rl, dl, pp, lm, km);
    idle_on = idle;
    for (int i = 0; i < n; i++) send_word(random_word());
  endtask

  initial begin
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    item_ch.valid <= 1'b0;
    item_ch.data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(mk(aps_pkg::ACT_TICK, 16'h0000, '0, '0, '0, 1'b0, '0, '0, '0));
    send_word(mk(aps_pkg::ACT_SET_WARN, 16'hFFFF, '0, '0, '0, 1'b0, '0, '0, '0));
    send_word(mk(aps_pkg::ACT_SET_ALARM, 16'hFFFF, '0, '0, '0, 1'b0, '0, '0, '0));
    send_word(mk(aps_pkg::ACT_CLR_ALARM, 16'hFFFF, '0, '0, '0, 1'b0, '0, '0, '0));
    send_word(mk(aps_pkg::ACT_CLR_WARN, 16'h00FF, '0, '0, '0, 1'b0, '0, '0, '0));
    send_word(mk(3'd6, 16'hFFFF, '1, '1, '1, 1'b1, '1, '1, '1));
    send_word(mk(3'd7, 16'hFFFF, '1, '1, '1, 1'b1, '1, '1, '1));
    send_word(mk(aps_pkg::ACT_CLEAR_ALL, 16'hFFFF, '0, '0, '0, 1'b0, '0, '0, '0));
    send_word(mk(aps_pkg::ACT_SET_ALARM, 16'h0060, '0, '0, '0, 1'b0, '0, '0, '0));
    send_word(mk(aps_pkg::ACT_TICK, 16'hFFFF, '1, '1, '1, 1'b1, '1, '1, '1));
    send_word(mk(aps_pkg::ACT_CLR_ALARM, 16'h0060, '0, '0, '0, 1'b0, '0, '0, '0));
    send_word(mk(aps_pkg::ACT_TICK, 16'h0000, '1, '0, '1, 1'b1, '1, '1, '1));
    send_word(mk(aps_pkg::ACT_SET_WARN, 16'h8001, '0, '0, '0, 1'b0, '0, '0, '0));

    load_config(1'b1, 8'd1, 8'd1, 4'd1, 16'hFFFF, 16'h0001);
    send_word(mk(aps_pkg::ACT_TICK, 16'h0000, '0, '0, '1, 1'b0, '1, '1, '0));
    send_word(mk(aps_pkg::ACT_TICK, 16'h0000, '1, '0, '1, 1'b1, '1, '0, '1));
    send_word(mk(aps_pkg::ACT_SET_ALARM, 16'h0040, '0, '0, '0, 1'b0, '0, '0, '0));
    send_word(mk(aps_pkg::ACT_TICK, 16'h0000, '0, '0, 5'b00001, 1'b1, '1, '0, '0));
    send_word(mk(aps_pkg::ACT_SET_ALARM, 16'h0004, '0, '0, '0, 1'b0, '0, '0, '0));
    send_word(mk(aps_pkg::ACT_TICK, 16'h0000, '0, '0, '0, 1'b1, '1, '0, '0));
    send_word(mk(aps_pkg::ACT_CLEAR_ALL, 16'h0000, '0, '0, '0, 1'b0, '0, '0, '0));
    send_word(mk(aps_pkg::ACT_TICK, 16'h0000, '0, '0, '1, 1'b1, '0, '0, '0));

    run_phase(1'b1, 8'd1, 8'd1, 4'd2, 16'hFFFF, 16'h0000, 1'b1, 115);
    run_phase(1'b1, 8'd3, 8'd4, 4'd0, 16'($urandom), 16'hFFFF, 1'b0, 115);
    run_phase(1'b0, 8'd255, 8'd255, 4'd15, 16'h0000, 16'($urandom), 1'b1, 110);
    run_phase(1'b1, 8'd0, 8'd0, 4'd1, 16'($urandom), 16'($urandom), 1'b1, 115);
    run_phase(1'b1, 8'd2, 8'd6, 4'd3, 16'h00FF, 16'hFF00, 1'b0, 115);
    run_phase(1'b1, 8'($urandom), 8'($urandom_range(1, 12)), 4'($urandom),
              16'($urandom), 16'($urandom), 1'b1, 115);

    item_ch.valid <= 1'b0;
    wait_drained();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/aps_pkg.sv
hw/rtl/aps_in_if.sv
hw/rtl/aps_out_if.sv
hw/rtl/aps_cfg.sv
hw/rtl/aps_lane.sv
hw/rtl/aps_merge.sv
hw/rtl/alarm_persistence_status_unit.sv
dv/aps_status_checker.sv
dv/tb.sv
